// ===== design/u2c_pkg.sv =====
// ----------------------------------------------------------------------------
// u2c_pkg: shared types, constants and the code point mapper
// Result record, push bundle and the CP1252 upper-half lookup.
// ----------------------------------------------------------------------------
package u2c_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic [7:0]  QMARK        = 8'h3F;
  localparam logic [7:0]  ASCII_TOP    = 8'h80;
  localparam logic [15:0] MIN_TWO_BYTE = 16'h0080;
  localparam logic [15:0] MIN_THREE    = 16'h0800;
  localparam logic [15:0] LATIN_LO     = 16'h00A0;
  localparam logic [15:0] LATIN_HI     = 16'h00FF;
  localparam logic [15:0] LIMIT_RESET  = 16'hFFFF;

  localparam logic [1:0] CONT_TAG  = 2'b10;
  localparam logic [2:0] LEAD2_TAG = 3'b110;
  localparam logic [3:0] LEAD3_TAG = 4'b1110;

  // Code point of each CP1252 byte 0x80..0x9F, zero where unassigned
  localparam logic [15:0] HI_TABLE [32] = '{
    16'h20AC, 16'h0000, 16'h201A, 16'h0192, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
    16'h02C6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h0000, 16'h017D, 16'h0000,
    16'h0000, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
    16'h02DC, 16'h2122, 16'h0161, 16'h203A, 16'h0153, 16'h0000, 16'h017E, 16'h0178
  };

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        string_end;
    logic [15:0] byte_count;
  } result_t;

  typedef struct packed {
    logic        valid;
    logic [1:0]  num;
    result_t     r0;
    result_t     r1;
  } push_t;

  function automatic logic [7:0] map_code(input logic [15:0] cp);
    logic [7:0] res;
    res = QMARK;
    if ((cp < MIN_TWO_BYTE) || ((cp >= LATIN_LO) && (cp <= LATIN_HI))) begin
      res = cp[7:0];
    end else begin
      for (int i = 0; i < 32; i++) begin
        if ((HI_TABLE[i] != 16'h0000) && (HI_TABLE[i] == cp)) begin
          res = ASCII_TOP | 8'(i);
        end
      end
    end
    return res;
  endfunction

endpackage

// ===== design/u2c_decode.sv =====
// ----------------------------------------------------------------------------
// u2c_decode: UTF-8 sequence assembly and CP1252 mapping
// Holds the sequence state and byte count, decodes one byte per accept.
// ----------------------------------------------------------------------------
module u2c_decode (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic [15:0]     cfg_wdata,
  input  logic            accept,
  input  logic [7:0]      in_byte,
  output u2c_pkg::push_t  push
);

  logic [15:0] limit_r;
  logic [1:0]  pend_r, pend_nxt;
  logic [15:0] part_r, part_nxt;
  logic        three_r, three_nxt;
  logic [15:0] cnt_r, cnt_nxt;

  logic        e1, e2, term;
  logic [7:0]  e1_byte, e2_byte;
  logic [15:0] cnt1;
  logic [15:0] pc;
  logic        ok0;

  always_comb begin
    pend_nxt  = pend_r;
    part_nxt  = part_r;
    three_nxt = three_r;
    e1        = 1'b0;
    e2        = 1'b0;
    term      = 1'b0;
    e1_byte   = u2c_pkg::QMARK;
    e2_byte   = u2c_pkg::QMARK;
    pc        = {part_r[9:0], in_byte[5:0]};
    ok0       = (cnt_r < limit_r);
    cnt1      = cnt_r;

    if (in_byte == 8'h00) begin
      e1        = (pend_r != 2'd0) && ok0;
      cnt1      = cnt_r + {15'd0, e1};
      e2        = 1'b1;
      term      = 1'b1;
      e2_byte   = 8'h00;
      pend_nxt  = 2'd0;
      part_nxt  = 16'd0;
      three_nxt = 1'b0;
    end else if ((pend_r != 2'd0) && (in_byte[7:6] == u2c_pkg::CONT_TAG)) begin
      pend_nxt = pend_r - 2'd1;
      if (pend_r == 2'd1) begin
        e1 = ok0;
        if (pc < (three_r ? u2c_pkg::MIN_THREE : u2c_pkg::MIN_TWO_BYTE)) begin
          e1_byte = u2c_pkg::QMARK;
        end else begin
          e1_byte = u2c_pkg::map_code(pc);
        end
        part_nxt = 16'd0;
      end else begin
        part_nxt = pc;
      end
      cnt1 = cnt_r + {15'd0, e1};
    end else begin
      // broken sequence: flag it, then take the byte afresh
      if (pend_r != 2'd0) begin
        e1       = ok0;
        pend_nxt = 2'd0;
        part_nxt = 16'd0;
      end
      cnt1 = cnt_r + {15'd0, e1};
      priority if (in_byte < u2c_pkg::ASCII_TOP) begin
        e2      = (cnt1 < limit_r);
        e2_byte = in_byte;
      end else if (in_byte[7:5] == u2c_pkg::LEAD2_TAG) begin
        part_nxt  = {11'd0, in_byte[4:0]};
        pend_nxt  = 2'd1;
        three_nxt = 1'b0;
      end else if (in_byte[7:4] == u2c_pkg::LEAD3_TAG) begin
        part_nxt  = {12'd0, in_byte[3:0]};
        pend_nxt  = 2'd2;
        three_nxt = 1'b1;
      end else begin
        e2 = (cnt1 < limit_r);
      end
    end

    cnt_nxt = term ? 16'd0 : (cnt1 + {15'd0, e2});

    push.valid         = accept && (e1 || e2);
    push.num           = {1'b0, e1} + {1'b0, e2};
    push.r1.out_byte   = e2_byte;
    push.r1.string_end = term;
    push.r1.byte_count = term ? cnt1 : 16'd0;
    if (e1) begin
      push.r0.out_byte   = e1_byte;
      push.r0.string_end = 1'b0;
      push.r0.byte_count = 16'd0;
    end else begin
      push.r0 = push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= u2c_pkg::LIMIT_RESET;
      pend_r  <= 2'd0;
      part_r  <= 16'd0;
      three_r <= 1'b0;
      cnt_r   <= 16'd0;
    end else begin
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
      if (accept) begin
        pend_r  <= pend_nxt;
        part_r  <= part_nxt;
        three_r <= three_nxt;
        cnt_r   <= cnt_nxt;
      end
    end
  end

endmodule

// ===== design/u2c_queue.sv =====
// ----------------------------------------------------------------------------
// u2c_queue: result queue
// Small register queue that takes up to two results a cycle, gives one while out_stall is low.
// ----------------------------------------------------------------------------
module u2c_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  u2c_pkg::push_t   push,
  output logic             full2,
  output logic             out_valid,
  input  logic             out_stall,
  output u2c_pkg::result_t out_res
);

  u2c_pkg::result_t mem_r [u2c_pkg::QueueDepth];

  logic [u2c_pkg::QueuePtrW-1:0] wr_r, wr_nxt, rd_r, rd_nxt, wr_hi;
  logic [u2c_pkg::QueueCntW-1:0] cnt_r, cnt_nxt;
  logic [1:0]                    push_num;
  logic                          pop;

  assign push_num  = push.valid ? push.num : 2'd0;
  assign out_valid = (cnt_r != '0);
  assign out_res   = mem_r[rd_r];
  assign pop       = out_valid && !out_stall;
  // hold off requests unless room for two results remains
  assign full2     = (cnt_r > u2c_pkg::QueueCntW'(u2c_pkg::QueueDepth - 2));

  assign wr_hi   = wr_r + u2c_pkg::QueuePtrW'(1);
  assign wr_nxt  = wr_r + u2c_pkg::QueuePtrW'(push_num);
  assign rd_nxt  = rd_r + u2c_pkg::QueuePtrW'(pop);
  assign cnt_nxt = cnt_r + u2c_pkg::QueueCntW'(push_num) - u2c_pkg::QueueCntW'(pop);

  always_ff @(posedge clk) begin
    if (push_num != 2'd0) begin
      mem_r[wr_r] <= push.r0;
    end
    if (push_num == 2'd2) begin
      mem_r[wr_hi] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== design/utf8_to_cp1252_decoder.sv =====
// ----------------------------------------------------------------------------
// utf8_to_cp1252_decoder: UTF-8 to CP1252 string converter
// Turns a zero-terminated UTF-8 byte stream into CP1252 bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall/in_byte takes one UTF-8 byte per request;
//   a zero byte ends the string. The output channel out_valid/out_stall gives
//   CP1252 bytes; the request that closes a string has out_string_end set,
//   out_byte zero and out_byte_count the bytes produced for that string.
//   cfg_we/cfg_wdata set the output limit (reset 65535); write it only while
//   the block is idle.
//   A byte is decoded combinationally when it is accepted and its results
//   are registered into the result queue. The input takes one byte per cycle
//   while the result queue has room. A byte that yields two results (broken
//   sequence followed by a byte, or the terminator after an unfinished
//   sequence) fills two queue slots, so the input stalls while the four-entry
//   result queue has fewer than two free slots.
//   When the receiver stalls, the queue fills and in_stall rises; nothing
//   is dropped. Reset clears the sequence state, byte count and queue.
// ----------------------------------------------------------------------------
module utf8_to_cp1252_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_string_end,
  output logic [15:0] out_byte_count
);

  u2c_pkg::push_t   push;
  u2c_pkg::result_t res;
  logic             accept;
  logic             full2;

  assign in_stall = full2;
  assign accept   = in_valid && !full2;

  u2c_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .in_byte   (in_byte),
    .push      (push)
  );

  u2c_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full2     (full2),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (res)
  );

  assign out_byte       = res.out_byte;
  assign out_string_end = res.string_end;
  assign out_byte_count = res.byte_count;

endmodule

// ===== tb/cp1252_stream_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cp1252_stream_checker: result predictor and comparator
// Watches the byte and result channels of the UTF-8 to CP1252 decoder. It
// decodes each accepted request on its own, queues the CP1252 bytes and
// terminators it expects, and compares every accepted result with them.
// ----------------------------------------------------------------------------
module cp1252_stream_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  out_byte,
  input  logic        out_string_end,
  input  logic [15:0] out_byte_count,
  output int          fail_count,
  output int          outstanding,
  output int          results_checked,
  output int          strings_closed
);

  u2c_pkg::result_t cp1252_expected [$];
  logic [15:0] byte_limit;
  logic [1:0]  cont_left;
  logic [15:0] code_acc;
  logic [15:0] bytes_made;
  logic        seq_is_three;

  function automatic logic [7:0] cp1252_of(input logic [15:0] cp);
    if ((cp < u2c_pkg::MIN_TWO_BYTE) ||
        ((cp >= u2c_pkg::LATIN_LO) && (cp <= u2c_pkg::LATIN_HI))) begin
      return cp[7:0];
    end
    unique case (cp)
      16'h20AC: return 8'h80;
      16'h201A: return 8'h82;
      16'h0192: return 8'h83;
      16'h201E: return 8'h84;
      16'h2026: return 8'h85;
      16'h2020: return 8'h86;
      16'h2021: return 8'h87;
      16'h02C6: return 8'h88;
      16'h2030: return 8'h89;
      16'h0160: return 8'h8A;
      16'h2039: return 8'h8B;
      16'h0152: return 8'h8C;
      16'h017D: return 8'h8E;
      16'h2018: return 8'h91;
      16'h2019: return 8'h92;
      16'h201C: return 8'h93;
      16'h201D: return 8'h94;
      16'h2022: return 8'h95;
      16'h2013: return 8'h96;
      16'h2014: return 8'h97;
      16'h02DC: return 8'h98;
      16'h2122: return 8'h99;
      16'h0161: return 8'h9A;
      16'h203A: return 8'h9B;
      16'h0153: return 8'h9C;
      16'h017E: return 8'h9E;
      16'h0178: return 8'h9F;
      default:  return u2c_pkg::QMARK;
    endcase
  endfunction

  // Drop anything past the limit; the terminator bypasses this.
  task automatic give_byte(input logic [7:0] b);
    u2c_pkg::result_t r;
    if (bytes_made < byte_limit) begin
      r.out_byte   = b;
      r.string_end = 1'b0;
      r.byte_count = 16'd0;
      cp1252_expected.push_back(r);
      bytes_made = bytes_made + 16'd1;
    end
  endtask

  task automatic start_sequence(input logic [7:0] b);
    if (!b[7]) begin
      give_byte(b);
    end else if (b[7:5] == u2c_pkg::LEAD2_TAG) begin
      code_acc     = {11'd0, b[4:0]};
      cont_left    = 2'd1;
      seq_is_three = 1'b0;
    end else if (b[7:4] == u2c_pkg::LEAD3_TAG) begin
      code_acc     = {12'd0, b[3:0]};
      cont_left    = 2'd2;
      seq_is_three = 1'b1;
    end else begin
      give_byte(u2c_pkg::QMARK);
    end
  endtask

  task automatic decode_utf8_byte(input logic [7:0] b);
    u2c_pkg::result_t term;
    logic [15:0] floor_cp;
    if (b == 8'h00) begin
      if (cont_left != 2'd0) begin
        give_byte(u2c_pkg::QMARK);
      end
      term.out_byte   = 8'h00;
      term.string_end = 1'b1;
      term.byte_count = bytes_made;
      cp1252_expected.push_back(term);
      cont_left    = 2'd0;
      code_acc     = 16'd0;
      bytes_made   = 16'd0;
      seq_is_three = 1'b0;
      return;
    end
    if (cont_left != 2'd0) begin
      if (b[7:6] == u2c_pkg::CONT_TAG) begin
        code_acc  = {code_acc[9:0], b[5:0]};
        cont_left = cont_left - 2'd1;
        if (cont_left == 2'd0) begin
          floor_cp = seq_is_three ? u2c_pkg::MIN_THREE : u2c_pkg::MIN_TWO_BYTE;
          give_byte((code_acc < floor_cp) ? u2c_pkg::QMARK : cp1252_of(code_acc));
          code_acc = 16'd0;
        end
        return;
      end
      // broken sequence: flag it, then take this byte as a new start
      give_byte(u2c_pkg::QMARK);
      cont_left = 2'd0;
      code_acc  = 16'd0;
    end
    start_sequence(b);
  endtask

  always @(posedge clk) begin
    u2c_pkg::result_t got;
    u2c_pkg::result_t want;
    if (!rst_n) begin
      cp1252_expected.delete();
      byte_limit      = u2c_pkg::LIMIT_RESET;
      cont_left       = 2'd0;
      code_acc        = 16'd0;
      bytes_made      = 16'd0;
      seq_is_three    = 1'b0;
      fail_count      = 0;
      results_checked = 0;
      strings_closed  = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got.out_byte   = out_byte;
        got.string_end = out_string_end;
        got.byte_count = out_byte_count;
        results_checked++;
        if (out_string_end) begin
          strings_closed++;
        end
        if (cp1252_expected.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result byte %h end %b count %0d",
                   $time, got.out_byte, got.string_end, got.byte_count);
        end else begin
          want = cp1252_expected.pop_front();
          if ((got.out_byte != want.out_byte) || (got.string_end != want.string_end) ||
              (got.byte_count != want.byte_count)) begin
            fail_count++;
            $display("%0t: mismatch byte exp %h got %h, end exp %b got %b, count exp %0d got %0d",
                     $time, want.out_byte, got.out_byte, want.string_end,
                     got.string_end, want.byte_count, got.byte_count);
          end
        end
      end
      if (cfg_we) begin
        byte_limit = cfg_wdata;
      end
      if (in_valid && !in_stall) begin
        decode_utf8_byte(in_byte);
      end
    end
    outstanding = cp1252_expected.size();
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: UTF-8 to CP1252 decoder test
// Feeds zero-terminated UTF-8 strings, well-formed and broken, under several
// output limits, with random sender gaps and receiver stalls, and leaves the
// checking to the stream checker beside the block.
// ----------------------------------------------------------------------------
module testbench;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_byte;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_byte;
  logic        out_string_end;
  logic [15:0] out_byte_count;

  int fail_count;
  int outstanding;
  int results_checked;
  int strings_closed;
  int burst_left;
  int bytes_sent;
  int strings_sent;

  // code points that CP1252 places in 0x80..0x9F
  logic [15:0] special_cp [27] = '{
    16'h20AC, 16'h201A, 16'h0192, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
    16'h02C6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h017D, 16'h2018,
    16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014, 16'h02DC,
    16'h2122, 16'h0161, 16'h203A, 16'h0153, 16'h017E, 16'h0178
  };

  utf8_to_cp1252_decoder u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_string_end (out_string_end),
    .out_byte_count (out_byte_count)
  );

  cp1252_stream_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte         (in_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_string_end  (out_string_end),
    .out_byte_count  (out_byte_count),
    .fail_count      (fail_count),
    .outstanding     (outstanding),
    .results_checked (results_checked),
    .strings_closed  (strings_closed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

  // Receiver: one long hold early on, then random stall patterns.
  initial begin
    int mode;
    int span;
    int hold_count;
    logic [7:0] pattern;
    out_stall = 1'b0;
    @(posedge rst_n);
    repeat (150) @(negedge clk);
    hold_count = 0;
    while (hold_count < 60) begin
      out_stall <= 1'b1;
      @(negedge clk);
      hold_count++;
    end
    forever begin
      mode    = $urandom_range(0, 3);
      span    = $urandom_range(20, 200);
      pattern = 8'($urandom);
      for (int i = 0; i < span; i++) begin
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 99) < 35);
          2: out_stall <= pattern[i % 8];
          default: out_stall <= (i < span / 2);
        endcase
        @(negedge clk);
      end
    end
  end

  // Offer one request and hold it until accepted; leave valid high after.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 120) : $urandom_range(1, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    burst_left--;
    bytes_sent++;
  endtask

  task automatic send_code(input logic [15:0] cp);
    if (cp < 16'h0080) begin
      send_byte(cp[7:0]);
    end else if (cp < 16'h0800) begin
      send_byte({u2c_pkg::LEAD2_TAG, cp[10:6]});
      send_byte({u2c_pkg::CONT_TAG, cp[5:0]});
    end else begin
      send_byte({u2c_pkg::LEAD3_TAG, cp[15:12]});
      send_byte({u2c_pkg::CONT_TAG, cp[11:6]});
      send_byte({u2c_pkg::CONT_TAG, cp[5:0]});
    end
  endtask

  task automatic send_noise();
    case ($urandom_range(0, 4))
      0: send_byte({u2c_pkg::CONT_TAG, 6'($urandom)});
      1: send_byte(8'($urandom_range(8'hF0, 8'hFF)));
      2: begin
        // lead cut short by a plain byte, by another lead or by an invalid byte
        if ($urandom_range(0, 1) == 0) begin
          send_byte({u2c_pkg::LEAD2_TAG, 5'($urandom)});
        end else begin
          send_byte({u2c_pkg::LEAD3_TAG, 4'($urandom)});
          if ($urandom_range(0, 1) == 0) send_byte({u2c_pkg::CONT_TAG, 6'($urandom)});
        end
        if ($urandom_range(0, 1) == 0) send_byte(8'($urandom_range(1, 127)));
        else send_byte(8'($urandom_range(8'hC0, 8'hFF)));
      end
      3: begin
        send_byte({u2c_pkg::LEAD2_TAG, 4'h0, 1'($urandom)});
        send_byte({u2c_pkg::CONT_TAG, 6'($urandom)});
      end
      default: begin
        send_byte({u2c_pkg::LEAD3_TAG, 4'h0});
        send_byte({u2c_pkg::CONT_TAG, 1'b0, 5'($urandom)});
        send_byte({u2c_pkg::CONT_TAG, 6'($urandom)});
      end
    endcase
  endtask

  task automatic send_random_string();
    int pieces;
    int k;
    pieces = $urandom_range(0, 14);
    repeat (pieces) begin
      k = $urandom_range(0, 99);
      if (k < 30)      send_code(16'($urandom_range(1, 127)));
      else if (k < 45) send_code(16'($urandom_range(u2c_pkg::LATIN_LO, u2c_pkg::LATIN_HI)));
      else if (k < 60) send_code(special_cp[$urandom_range(0, 26)]);
      else if (k < 68) send_code(16'($urandom_range(16'h0080, 16'h009F)));
      else if (k < 75) send_code(16'($urandom_range(16'h0100, 16'h07FF)));
      else if (k < 82) send_code(16'($urandom_range(16'h0800, 16'hFFFF)));
      else             send_noise();
    end
    // sometimes end the string inside a sequence
    if ($urandom_range(0, 9) == 0) send_byte({u2c_pkg::LEAD3_TAG, 4'($urandom)});
    send_byte(8'h00);
    strings_sent++;
  endtask

  // Drain the block, then write the limit.
  task automatic set_limit(input logic [15:0] v);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we     <= 1'b0;
    burst_left = 0;
  endtask

  initial begin
    logic [7:0]  directed_bytes [$];
    logic [15:0] phase_limit [7];
    int          phase_start;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_wdata    = 16'd0;
    in_valid     = 1'b0;
    in_byte      = 8'h00;
    burst_left   = 0;
    bytes_sent   = 0;
    strings_sent = 0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    set_limit(u2c_pkg::LIMIT_RESET);
    // ASCII, Latin-1, table hits, unassigned C1, then stray, long lead,
    // overlongs, surrogate, broken pair and end inside a sequence
    directed_bytes = '{8'h41, 8'hC2, 8'hA0, 8'hC3, 8'hBF, 8'hE2, 8'h82, 8'hAC,
                       8'hC5, 8'hB8, 8'hC2, 8'h80, 8'h00,
                       8'h80, 8'hFF, 8'hC0, 8'h81, 8'hE0, 8'h80, 8'h80,
                       8'hED, 8'hA0, 8'h80, 8'hC3, 8'h41, 8'hE2, 8'h82, 8'h00};
    foreach (directed_bytes[i]) send_byte(directed_bytes[i]);
    strings_sent += 2;

    phase_limit = '{u2c_pkg::LIMIT_RESET, 16'd0, 16'd1, 16'd2,
                    16'($urandom_range(3, 24)), 16'($urandom), u2c_pkg::LIMIT_RESET};
    foreach (phase_limit[p]) begin
      set_limit(phase_limit[p]);
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < 270) send_random_string();
    end

    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    $display("Covered %0d bytes in %0d strings over 8 limit settings, 0 and 65535 included;",
             bytes_sent, strings_sent);
    $display("%0d results checked, %0d of them terminators.", results_checked, strings_closed);
    if ((fail_count == 0) && (outstanding == 0)) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
